// ----- rtl/core/scfr_pkg.sv -----
// Shared types and constants of the serial command frame receiver.
package scfr_pkg;

    localparam logic [7:0] KEY_FIRST   = 8'h24;
    localparam logic [7:0] KEY_SECOND  = 8'h40;
    localparam logic [3:0] OWN_ADDR_RST  = 4'd1;
    localparam logic [6:0] LEN_LIMIT_RST = 7'd79;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_READ    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_ACCEPT  = 3'd1,
        EV_BADSUM  = 3'd2,
        EV_IGNORED = 3'd3,
        EV_REJECT  = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        ST_HUNT   = 3'd0,
        ST_SECOND = 3'd1,
        ST_ADDR   = 3'd2,
        ST_LEN    = 3'd3,
        ST_DATA   = 3'd4,
        ST_SUM    = 3'd5
    } stage_t;

    typedef enum logic {
        REG_OWN_ADDR  = 1'b0,
        REG_LEN_LIMIT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] rx_byte;
        logic [6:0] read_index;
        logic       key_first;
        logic       key_second;
    } item_t;

endpackage

// ----- rtl/core/scfr_if.sv -----
// Request and result channel interfaces of the frame receiver.
interface scfr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] rx_byte;
    logic [6:0] read_index;

    modport source (output valid, output opcode, output rx_byte, output read_index,
                    input ready);
    modport sink (input valid, input opcode, input rx_byte, input read_index,
                  output ready);
endinterface

interface scfr_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic       frame_held;
    logic [6:0] payload_len;
    logic [7:0] read_data;

    modport source (output valid, output event_res, output frame_held,
                    output payload_len, output read_data, input ready);
    modport sink (input valid, input event_res, input frame_held,
                  input payload_len, input read_data, output ready);
endinterface

// ----- rtl/core/scfr_front.sv -----
// Front end: accept requests and classify opcode and byte.
module scfr_front (
    scfr_req_if.sink          req,
    input  logic              full,
    output logic              push,
    output scfr_pkg::item_t   item
);
    import scfr_pkg::*;

    assign req.ready = ~full;
    assign push      = req.valid & ~full;

    always_comb
    begin
        item.cmd        = cmd_t'(req.opcode);
        item.rx_byte    = req.rx_byte;
        item.read_index = req.read_index;
        item.key_first  = (req.rx_byte == KEY_FIRST);
        item.key_second = (req.rx_byte == KEY_SECOND);
    end

endmodule

// ----- rtl/core/scfr_queue.sv -----
// Short queue between the front end and the frame engine.
module scfr_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  scfr_pkg::item_t   push_item,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output scfr_pkg::item_t   q_item
);
    import scfr_pkg::*;

    item_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/core/scfr_back.sv -----
// Frame engine: hunt, check and hold frames, store and read payload.
module scfr_back #(
    parameter int BUFFER_DEPTH = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [3:0]        own_address,
    input  logic [6:0]        length_limit,
    input  logic              q_valid,
    input  scfr_pkg::item_t   q_item,
    output logic              pop,
    scfr_rsp_if.source        rsp
);
    import scfr_pkg::*;

    localparam int         IDX_W   = $clog2(BUFFER_DEPTH);
    localparam logic [8:0] DEPTH_L = 9'(BUFFER_DEPTH);

    logic [7:0] mem [BUFFER_DEPTH];

    stage_t     stage_reg;
    stage_t     stage_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [6:0] exp_len_reg;
    logic [6:0] exp_len_next;
    logic [6:0] count_reg;
    logic [6:0] count_next;
    logic       held_reg;
    logic       held_next;
    event_t     ev;
    logic       wr_en;
    logic       rd_en;
    logic [8:0] wr_ext;
    logic [8:0] rd_ext;

    logic       out_valid_reg;
    event_t     out_event_reg;
    logic       out_held_reg;
    logic [6:0] out_len_reg;
    logic [7:0] out_data_reg;

    assign pop    = q_valid & (~out_valid_reg | rsp.ready);
    assign wr_ext = 9'(count_reg);
    assign rd_ext = 9'(q_item.read_index);
    assign rd_en  = (q_item.cmd == CMD_READ) && (rd_ext < DEPTH_L);

    always_comb
    begin
        stage_next   = stage_reg;
        sum_next     = sum_reg;
        exp_len_next = exp_len_reg;
        count_next   = count_reg;
        held_next    = held_reg;
        ev           = EV_NONE;
        wr_en        = 1'b0;
        unique case (q_item.cmd)
            CMD_BYTE:
            begin
                if (held_reg)
                begin
                    ev = EV_IGNORED;
                end
                else
                begin
                    unique case (stage_reg)
                        ST_SECOND:
                        begin
                            if (q_item.key_second)
                            begin
                                sum_next   = sum_reg + q_item.rx_byte;
                                stage_next = ST_ADDR;
                            end
                            else
                            begin
                                stage_next = ST_HUNT;
                                ev         = EV_REJECT;
                            end
                        end
                        ST_ADDR:
                        begin
                            if (q_item.rx_byte[3:0] == own_address)
                            begin
                                sum_next   = sum_reg + q_item.rx_byte;
                                stage_next = ST_LEN;
                            end
                            else
                            begin
                                stage_next = ST_HUNT;
                                ev         = EV_REJECT;
                            end
                        end
                        ST_LEN:
                        begin
                            if (q_item.rx_byte <= {1'b0, length_limit})
                            begin
                                sum_next     = sum_reg + q_item.rx_byte;
                                exp_len_next = q_item.rx_byte[6:0];
                                count_next   = '0;
                                stage_next   = (q_item.rx_byte[6:0] == '0) ? ST_SUM : ST_DATA;
                            end
                            else
                            begin
                                stage_next = ST_HUNT;
                                ev         = EV_REJECT;
                            end
                        end
                        ST_DATA:
                        begin
                            sum_next   = sum_reg + q_item.rx_byte;
                            wr_en      = (wr_ext < DEPTH_L);
                            count_next = count_reg + 7'd1;
                            if (count_next == exp_len_reg)
                            begin
                                stage_next = ST_SUM;
                            end
                        end
                        ST_SUM:
                        begin
                            if (sum_reg == q_item.rx_byte)
                            begin
                                held_next = 1'b1;
                                ev        = EV_ACCEPT;
                            end
                            else
                            begin
                                ev = EV_BADSUM;
                            end
                            stage_next = ST_HUNT;
                        end
                        default:
                        begin
                            if (q_item.key_first)
                            begin
                                sum_next   = q_item.rx_byte;
                                stage_next = ST_SECOND;
                            end
                            else
                            begin
                                stage_next = ST_HUNT;
                            end
                        end
                    endcase
                end
            end
            CMD_RELEASE:
            begin
                held_next = 1'b0;
            end
            CMD_READ, CMD_NOP:
            begin
                ev = EV_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg     <= ST_HUNT;
            sum_reg       <= '0;
            exp_len_reg   <= '0;
            count_reg     <= '0;
            held_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                stage_reg   <= stage_next;
                sum_reg     <= sum_next;
                exp_len_reg <= exp_len_next;
                count_reg   <= count_next;
                held_reg    <= held_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && wr_en)
        begin
            mem[wr_ext[IDX_W-1:0]] <= q_item.rx_byte;
        end
        if (pop)
        begin
            out_event_reg <= ev;
            out_held_reg  <= held_next;
            out_len_reg   <= exp_len_next;
            out_data_reg  <= rd_en ? mem[rd_ext[IDX_W-1:0]] : 8'd0;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.event_res    = out_event_reg;
    assign rsp.frame_held   = out_held_reg;
    assign rsp.payload_len  = out_len_reg;
    assign rsp.read_data    = out_data_reg;

endmodule

// ----- rtl/core/serial_command_frame_receiver.sv -----
// Top level of the serial command frame receiver.
//
// req carries one request per valid/ready handshake: opcode 0 feeds a
// received byte, 1 reads a stored payload byte, 2 releases a held frame.
// rsp returns exactly one result per request, in order: event code, held
// flag, current frame length and read data.
// Frames are '$', '@', address, length, payload, 8-bit additive checksum.
// A request is classified on entry and waits in a two-entry queue; the
// frame engine takes one request per cycle into its result register
// while rsp is not stalled. A request is registered in the queue slot and
// then in the result register before its result is valid on rsp.
// A stalled rsp holds the result; req keeps accepting until the queue is
// full, then ready drops until rsp drains.
// The APB port holds own_address at 0x0 and length_limit at 0x4; write
// them only while no request is in flight.
// Reset returns the engine to hunting, clears the held flag and loads
// own_address 1 and length_limit 79; the payload store is not cleared.
module serial_command_frame_receiver #(
    parameter int BUFFER_DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    scfr_req_if.sink    req,
    scfr_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import scfr_pkg::*;

    logic [3:0] own_addr_reg;
    logic [6:0] len_limit_reg;
    logic       cfg_wr;
    reg_idx_t   cfg_idx;
    logic       full;
    logic       push;
    item_t      push_item;
    logic       pop;
    logic       q_valid;
    item_t      q_item;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg  <= OWN_ADDR_RST;
            len_limit_reg <= LEN_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_OWN_ADDR:  own_addr_reg  <= pwdata[3:0];
                REG_LEN_LIMIT: len_limit_reg <= pwdata[6:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_OWN_ADDR:  prdata = 32'(own_addr_reg);
            REG_LEN_LIMIT: prdata = 32'(len_limit_reg);
        endcase
    end

    scfr_front u_front (
        .req  (req),
        .full (full),
        .push (push),
        .item (push_item)
    );

    scfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    scfr_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .own_address  (own_addr_reg),
        .length_limit (len_limit_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .pop          (pop),
        .rsp          (rsp)
    );

endmodule
